// ----- hdl/drt_pkg.sv -----
// Package for the dirty region table: sizes, operation and status codes,
// the entry type carried along the cell chain and the cell control struct.
// No dependencies.
package drt_pkg;

  // Table size and derived widths.
  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned STEP_W      = $clog2(MAX_ENTRIES + 2);

  // Fixed field widths of the ports.
  localparam int unsigned OPC_W       = 2;
  localparam int unsigned START_W     = 24;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 9;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_REGISTER = 2'd1,
    OP_COALESCE = 2'd2,
    OP_READ     = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_COVERED  = 3'd0,
    ST_ENLARGED = 3'd1,
    ST_ADDED    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  // One table entry as it travels through the chain.
  typedef struct packed {
    logic               valid;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_SORT  = 2'd2,
    CELL_INIT  = 2'd3
  } cell_op_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_e         op;
    logic             phase;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  // Sort key: valid entries first, then ascending start address.
  function automatic logic [START_W:0] sort_key(input entry_t e);
    return {~e.valid, e.start};
  endfunction

endpackage

// ----- hdl/dirty_region_table_core.sv -----
// Top level of the dirty region table: a ring of drt_cell entries and the
// sequencer that scans, sorts and merges them. Depends on drt_pkg, drt_cell.
//
//   channel   | direction | handshake                 | beat content
//   ----------+-----------+---------------------------+-------------------------------
//   command   | in        | start_i high, busy_o low  | opcode, region start/length, index
//   result    | out       | done_o high for one cycle | status, entry start/length/valid, count
//
// Clear finishes without leaving idle; its result shows in the next cycle.
// Register and read rotate the whole ring once past cell 0.
// Coalesce marks the entries in use, then runs an odd-even sort, a merge
// rotation and a compacting sort. busy_o stays high until the result beat.
// Reset empties the table at once; no clearing pass. The receiver cannot stall.
module dirty_region_table_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [drt_pkg::OPC_W-1:0]        opcode_i,
  input  logic [drt_pkg::START_W-1:0]      region_start_i,
  input  logic [drt_pkg::LEN_W-1:0]        region_length_i,
  input  logic [drt_pkg::INDEX_W-1:0]      entry_index_i,
  output logic                             done_o,
  output logic [drt_pkg::STATUS_W-1:0]     status_o,
  output logic [drt_pkg::START_W-1:0]      entry_start_o,
  output logic [drt_pkg::LEN_W-1:0]        entry_length_o,
  output logic                             entry_valid_o,
  output logic [drt_pkg::COUNT_OUT_W-1:0]  entry_count_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_INIT  = 6'b000100,
    S_SORT1 = 6'b001000,
    S_MERGE = 6'b010000,
    S_SORT2 = 6'b100000
  } state_e;

  localparam int unsigned MAXE = drt_pkg::MAX_ENTRIES;

  state_e                              state_q, state_d;
  logic [drt_pkg::STEP_W-1:0]          step_q, step_d;
  logic [drt_pkg::CNT_W-1:0]           count_q, count_d;
  drt_pkg::opcode_e                    op_q, op_d;
  logic [drt_pkg::START_W-1:0]         start_q, start_d;
  logic [drt_pkg::LEN_W-1:0]           len_q, len_d;
  logic [drt_pkg::INDEX_W-1:0]         idx_q, idx_d;
  logic                                found_q, found_d;
  drt_pkg::status_e                    stat_q, stat_d;
  drt_pkg::entry_t                     rd_q, rd_d;
  logic                                acc_v_q, acc_v_d;
  logic [drt_pkg::START_W-1:0]         acc_s_q, acc_s_d;
  logic [drt_pkg::LEN_W-1:0]           acc_l_q, acc_l_d;
  logic [drt_pkg::CNT_W-1:0]           ncnt_q, ncnt_d;

  logic                                done_q, done_d;
  drt_pkg::status_e                    ostat_q, ostat_d;
  drt_pkg::entry_t                     oent_q, oent_d;
  logic [drt_pkg::CNT_W-1:0]           ocnt_q, ocnt_d;

  drt_pkg::cell_ctrl_t                 ctrl;
  drt_pkg::entry_t                     cells [MAXE];
  drt_pkg::entry_t                     lefts [MAXE];
  drt_pkg::entry_t                     rights [MAXE];
  drt_pkg::entry_t                     head;
  drt_pkg::entry_t                     inject;
  logic                                in_use;
  logic [drt_pkg::START_W:0]           acc_end, head_end, far_end, span;

  // Ring of cells; cell 0 is the head that the sequencer examines.
  for (genvar g = 0; g < MAXE; g++) begin : g_cell
    drt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (drt_pkg::IDX_W'(g)),
      .left_i  (lefts[g]),
      .right_i (rights[g]),
      .entry_o (cells[g])
    );
  end

  // Neighbor wiring; the last cell takes the injected entry when shifting.
  always_comb begin
    for (int i = 0; i < MAXE; i++) begin
      lefts[i]  = (i == 0) ? cells[i] : cells[(i == 0) ? 0 : i - 1];
      rights[i] = (i == MAXE - 1) ? ((ctrl.op == drt_pkg::CELL_SORT) ? cells[i] : inject)
                                  : cells[(i == MAXE - 1) ? i : i + 1];
    end
  end

  assign head = cells[0];

  // Merge arithmetic on the accumulated group and the head entry.
  always_comb begin
    acc_end  = {1'b0, acc_s_q} + {{(drt_pkg::START_W + 1 - drt_pkg::LEN_W){1'b0}}, acc_l_q};
    head_end = {1'b0, head.start} + {{(drt_pkg::START_W + 1 - drt_pkg::LEN_W){1'b0}}, head.len};
    far_end  = (head_end > acc_end) ? head_end : acc_end;
    span     = far_end - {1'b0, acc_s_q};
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    op_d    = op_q;
    start_d = start_q;
    len_d   = len_q;
    idx_d   = idx_q;
    found_d = found_q;
    stat_d  = stat_q;
    rd_d    = rd_q;
    acc_v_d = acc_v_q;
    acc_s_d = acc_s_q;
    acc_l_d = acc_l_q;
    ncnt_d  = ncnt_q;
    done_d  = 1'b0;
    ostat_d = ostat_q;
    oent_d  = oent_q;
    ocnt_d  = ocnt_q;
    inject  = head;
    in_use  = (32'(step_q) < 32'(count_q));
    ctrl.op    = drt_pkg::CELL_HOLD;
    ctrl.phase = step_q[0];
    ctrl.count = count_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = drt_pkg::opcode_e'(opcode_i);
          start_d = region_start_i;
          len_d   = region_length_i;
          idx_d   = entry_index_i;
          step_d  = '0;
          found_d = 1'b0;
          stat_d  = drt_pkg::ST_DONE;
          rd_d    = '0;
          case (drt_pkg::opcode_e'(opcode_i))
            drt_pkg::OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
              ostat_d = drt_pkg::ST_DONE;
              oent_d  = '0;
              ocnt_d  = '0;
            end
            drt_pkg::OP_REGISTER, drt_pkg::OP_READ: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_INIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One full rotation; the head holds entry number step_q.
        ctrl.op = drt_pkg::CELL_SHIFT;
        step_d  = step_q + 1'b1;
        if (op_q == drt_pkg::OP_REGISTER) begin
          if (!found_q && in_use && head.start == start_q) begin
            found_d = 1'b1;
            if (head.len < len_q) begin
              inject.len = len_q;
              stat_d     = drt_pkg::ST_ENLARGED;
            end else begin
              stat_d = drt_pkg::ST_COVERED;
            end
          end else if (!found_q && 32'(step_q) == 32'(count_q)) begin
            inject = '{valid: 1'b1, start: start_q, len: len_q};
            stat_d = drt_pkg::ST_ADDED;
          end
        end else if (32'(idx_q) == 32'(step_q) && in_use) begin
          rd_d = '{valid: 1'b1, start: head.start, len: head.len};
        end
        if (step_q == drt_pkg::STEP_W'(MAXE - 1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (op_q == drt_pkg::OP_REGISTER) begin
            if (stat_d == drt_pkg::ST_ADDED) begin
              count_d = count_q + 1'b1;
            end
            ostat_d = (stat_d == drt_pkg::ST_DONE) ? drt_pkg::ST_OVERFLOW : stat_d;
            oent_d  = '0;
          end else begin
            ostat_d = drt_pkg::ST_DONE;
            oent_d  = rd_d;
          end
          ocnt_d = count_d;
        end
      end

      S_INIT: begin
        // Mark the entries in use before sorting.
        ctrl.op = drt_pkg::CELL_INIT;
        step_d  = '0;
        state_d = S_SORT1;
      end

      S_SORT1: begin
        ctrl.op = drt_pkg::CELL_SORT;
        step_d  = step_q + 1'b1;
        if (step_q == drt_pkg::STEP_W'(MAXE - 1)) begin
          state_d = S_MERGE;
          step_d  = '0;
          acc_v_d = 1'b0;
          ncnt_d  = '0;
        end
      end

      S_MERGE: begin
        // Sorted entries pass the head; groups collect in the accumulator
        // and leave through the tail as a new group starts.
        ctrl.op = drt_pkg::CELL_SHIFT;
        step_d  = step_q + 1'b1;
        if (head.valid && acc_v_q && ({1'b0, head.start} <= acc_end)) begin
          acc_l_d      = (|span[drt_pkg::START_W:drt_pkg::LEN_W]) ? '1
                                                                   : span[drt_pkg::LEN_W-1:0];
          inject.valid = 1'b0;
        end else begin
          inject = '{valid: acc_v_q, start: acc_s_q, len: acc_l_q};
          if (acc_v_q) begin
            ncnt_d = ncnt_q + 1'b1;
          end
          acc_v_d = head.valid;
          acc_s_d = head.start;
          acc_l_d = head.len;
        end
        if (step_q == drt_pkg::STEP_W'(MAXE)) begin
          state_d = S_SORT2;
          step_d  = '0;
          count_d = ncnt_d;
        end
      end

      S_SORT2: begin
        // Second sort moves the merged entries to the front in order.
        ctrl.op = drt_pkg::CELL_SORT;
        step_d  = step_q + 1'b1;
        if (step_q == drt_pkg::STEP_W'(MAXE - 1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          ostat_d = drt_pkg::ST_DONE;
          oent_d  = '0;
          ocnt_d  = count_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    op_q    <= op_d;
    start_q <= start_d;
    len_q   <= len_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    rd_q    <= rd_d;
    acc_v_q <= acc_v_d;
    acc_s_q <= acc_s_d;
    acc_l_q <= acc_l_d;
    ncnt_q  <= ncnt_d;
    ostat_q <= ostat_d;
    oent_q  <= oent_d;
    ocnt_q  <= ocnt_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = ostat_q;
  assign entry_start_o  = oent_q.start;
  assign entry_length_o = oent_q.len;
  assign entry_valid_o  = oent_q.valid;
  assign entry_count_o  = drt_pkg::COUNT_OUT_W'(ocnt_q);

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAXE))
    else $error("entry count above table size");

  // A result beat only appears once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  // An accepted command either starts work or gives its result beat in the next cycle.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command produced nothing");

  // Only a read can return a valid entry.
  a_valid_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && entry_valid_o) |-> (status_o == drt_pkg::ST_DONE))
    else $error("valid entry with a register status");

endmodule

// ----- hdl/drt_cell.sv -----
// One cell of the dirty region table chain: holds one entry and either
// keeps it, takes its right neighbor's entry, compare-swaps with a neighbor,
// or marks itself valid when its index is below the count. Depends on drt_pkg.
module drt_cell (
  input  logic                       clk_i,
  input  drt_pkg::cell_ctrl_t        ctrl_i,
  input  logic [drt_pkg::IDX_W-1:0]  idx_i,
  input  drt_pkg::entry_t            left_i,
  input  drt_pkg::entry_t            right_i,
  output drt_pkg::entry_t            entry_o
);

  drt_pkg::entry_t entry_q, entry_d;
  logic            is_low;

  // Next entry, chosen by the broadcast operation.
  always_comb begin
    is_low  = (idx_i[0] == ctrl_i.phase);
    entry_d = entry_q;
    case (ctrl_i.op)
      drt_pkg::CELL_HOLD: begin
        entry_d = entry_q;
      end
      drt_pkg::CELL_SHIFT: begin
        entry_d = right_i;
      end
      drt_pkg::CELL_SORT: begin
        // The lower cell of a pair keeps the smaller key, the upper the larger.
        if (is_low) begin
          if (drt_pkg::sort_key(entry_q) > drt_pkg::sort_key(right_i)) begin
            entry_d = right_i;
          end
        end else begin
          if (drt_pkg::sort_key(left_i) > drt_pkg::sort_key(entry_q)) begin
            entry_d = left_i;
          end
        end
      end
      drt_pkg::CELL_INIT: begin
        entry_d.valid = (drt_pkg::CNT_W'(idx_i) < ctrl_i.count);
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
